>>> rtl/core/i2cbm_pkg.sv
// Shared types and constants for the I2C bit-level master core.
package i2cbm_pkg;

   localparam int TICKS_W    = 10;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_START  = 3'd1;
   localparam logic [2:0] KIND_STOP   = 3'd2;
   localparam logic [2:0] KIND_WRITE  = 3'd3;
   localparam logic [2:0] KIND_RDACK  = 3'd4;
   localparam logic [2:0] KIND_RDNACK = 3'd5;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;
   localparam logic [1:0] PHASE_3 = 2'd3;

   typedef enum logic [5:0] {
      OP_IDLE   = 6'b000001,
      OP_START  = 6'b000010,
      OP_STOP   = 6'b000100,
      OP_WRITE  = 6'b001000,
      OP_RDACK  = 6'b010000,
      OP_RDNACK = 6'b100000
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         phase;
      logic [3:0]         bit_cnt;
      logic [7:0]         shift;
      logic [TICKS_W-1:0] ticks;
      logic               scl;
      logic               sda;
      logic               ack;
      logic               err;
   } state_type;

   // scl_level sits in the lowest bit
   typedef struct packed {
      logic       status;
      logic [7:0] rd_data;
      logic       ack_seen;
      logic       done_res;
      logic       busy_res;
      logic       sda_level;
      logic       scl_level;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

>>> rtl/core/i2cbm_engine.sv
// Bus phase state registers and the single-pass next-state logic.
module i2cbm_engine import i2cbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [2:0]         kind,
   input  logic [7:0]         wr_data,
   input  logic               sda_in,
   input  logic [TICKS_W-1:0] phase_ticks,
   output result_type         result
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      logic               done;
      logic               is_cmd;
      logic               is_tick;
      logic [TICKS_W-1:0] pt;
      logic [TICKS_W:0]   tick_sum;
      logic [3:0]         bc_next;
      logic [7:0]         sh_next;
      op_type             cmd_op;

      state_in = state_ff;
      done     = 1'b0;
      is_cmd   = (kind >= KIND_START) && (kind <= KIND_RDNACK);
      is_tick  = !is_cmd;
      pt       = (phase_ticks == '0) ? TICKS_W'(1) : phase_ticks;
      tick_sum = {1'b0, state_ff.ticks} + (TICKS_W+1)'(1);
      bc_next  = state_ff.bit_cnt + 4'd1;
      sh_next  = {state_ff.shift[6:0], 1'b0};

      case (kind)
         KIND_START: cmd_op = OP_START;
         KIND_STOP:  cmd_op = OP_STOP;
         KIND_WRITE: cmd_op = OP_WRITE;
         KIND_RDACK: cmd_op = OP_RDACK;
         default:    cmd_op = OP_RDNACK;
      endcase

      if (is_cmd && state_ff.op == OP_IDLE) begin
         state_in.op      = cmd_op;
         state_in.phase   = PHASE_0;
         state_in.bit_cnt = '0;
         state_in.ticks   = '0;
         case (cmd_op)
            OP_START: begin
               state_in.err = 1'b0;
               state_in.scl = 1'b1;
               state_in.sda = 1'b1;
            end
            OP_STOP: begin
               state_in.sda = 1'b0;
            end
            OP_WRITE: begin
               state_in.ack   = 1'b0;
               state_in.shift = wr_data;
               state_in.sda   = wr_data[7];
            end
            default: begin
               state_in.shift = '0;
               state_in.sda   = 1'b1;
            end
         endcase
      end else if (is_tick && state_ff.op != OP_IDLE) begin
         if (tick_sum >= {1'b0, pt}) begin
            state_in.ticks = '0;
            case (state_ff.op)
               OP_START: begin
                  if (state_ff.phase == PHASE_0) begin
                     if (!sda_in) begin
                        state_in.err = 1'b1;
                        done = 1'b1;
                     end else begin
                        state_in.sda   = 1'b0;
                        state_in.phase = PHASE_1;
                     end
                  end else if (state_ff.phase == PHASE_1) begin
                     if (sda_in) begin
                        state_in.err = 1'b1;
                        done = 1'b1;
                     end else begin
                        state_in.scl   = 1'b0;
                        state_in.phase = PHASE_2;
                     end
                  end else begin
                     done = 1'b1;
                  end
               end
               OP_STOP: begin
                  if (state_ff.phase == PHASE_0) begin
                     state_in.scl   = 1'b1;
                     state_in.phase = PHASE_1;
                  end else if (state_ff.phase == PHASE_1) begin
                     state_in.sda   = 1'b1;
                     state_in.phase = PHASE_2;
                  end else begin
                     done = 1'b1;
                  end
               end
               OP_WRITE: begin
                  if (state_ff.bit_cnt < BITS_PER_BYTE) begin
                     if (state_ff.phase == PHASE_0) begin
                        state_in.scl   = 1'b1;
                        state_in.phase = PHASE_1;
                     end else if (state_ff.phase == PHASE_1) begin
                        state_in.scl   = 1'b0;
                        state_in.phase = PHASE_2;
                     end else begin
                        state_in.shift   = sh_next;
                        state_in.bit_cnt = bc_next;
                        if (bc_next < BITS_PER_BYTE) begin
                           state_in.sda = sh_next[7];
                        end
                        state_in.phase = PHASE_0;
                     end
                  end else if (state_ff.phase == PHASE_0) begin
                     state_in.sda   = 1'b1;
                     state_in.phase = PHASE_1;
                  end else if (state_ff.phase == PHASE_1) begin
                     state_in.scl   = 1'b1;
                     state_in.phase = PHASE_2;
                  end else begin
                     state_in.ack = !sda_in;
                     state_in.scl = 1'b0;
                     done = 1'b1;
                  end
               end
               OP_RDACK, OP_RDNACK: begin
                  if (state_ff.bit_cnt < BITS_PER_BYTE) begin
                     if (state_ff.phase == PHASE_0) begin
                        state_in.scl   = 1'b1;
                        state_in.phase = PHASE_1;
                     end else if (state_ff.phase == PHASE_1) begin
                        state_in.shift = {state_ff.shift[6:0], sda_in};
                        state_in.phase = PHASE_2;
                     end else begin
                        state_in.scl     = 1'b0;
                        state_in.bit_cnt = bc_next;
                        if (bc_next == BITS_PER_BYTE) begin
                           state_in.sda = (state_ff.op == OP_RDNACK);
                        end
                        state_in.phase = PHASE_0;
                     end
                  end else if (state_ff.phase == PHASE_0) begin
                     state_in.scl   = 1'b1;
                     state_in.phase = PHASE_1;
                  end else if (state_ff.phase == PHASE_1) begin
                     state_in.scl   = 1'b0;
                     state_in.phase = PHASE_2;
                  end else if (state_ff.phase == PHASE_2 && state_ff.op == OP_RDACK) begin
                     state_in.sda   = 1'b1;
                     state_in.phase = PHASE_3;
                  end else begin
                     done = 1'b1;
                  end
               end
               default: begin
                  done = 1'b0;
               end
            endcase
            if (done) begin
               state_in.op      = OP_IDLE;
               state_in.phase   = PHASE_0;
               state_in.bit_cnt = '0;
            end
         end else begin
            state_in.ticks = tick_sum[TICKS_W-1:0];
         end
      end

      result.scl_level = state_in.scl;
      result.sda_level = state_in.sda;
      result.busy_res  = (state_in.op != OP_IDLE);
      result.done_res  = done;
      result.ack_seen  = state_in.ack;
      result.rd_data   = state_in.shift;
      result.status    = state_in.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.op      <= OP_IDLE;
         state_ff.phase   <= PHASE_0;
         state_ff.bit_cnt <= '0;
         state_ff.shift   <= '0;
         state_ff.ticks   <= '0;
         state_ff.scl     <= 1'b1;
         state_ff.sda     <= 1'b1;
         state_ff.ack     <= 1'b0;
         state_ff.err     <= 1'b0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/i2cbm_rsp_reg.sv
// Result register and output handshake.
module i2cbm_rsp_reg import i2cbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_type            result,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RESULT_W)'(0), data_ff};

endmodule

>>> rtl/core/i2c_bit_level_master_core.sv
// Top level of the I2C bit-level master core.
// Each req transaction is a tick or a command (tuser) that advances the bus phase machine;
// each one yields exactly one rsp transaction with the line drives and status after it.
// One transaction is taken per clock while the rsp side is not stalled; each passes the
// input register, then the phase logic into the result register. The CSR write sets ticks
// per bus phase (zero acts as one) and is always ready.
module i2c_bit_level_master_core import i2cbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // wr_data[7:0], sda_in[8], zero fill
   input  logic [2:0]            req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // scl_level, sda_level, busy_res, done_res,
                                             // ack_seen, rd_data[12:5], status, zero fill
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TICKS_W-1:0]    csr_data
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [2:0]         kind_ff;
   logic [7:0]         wr_data_ff;
   logic               sda_in_ff;
   logic [TICKS_W-1:0] phase_ticks_ff;
   logic               out_free;
   logic               advance;
   result_type         result;

   assign advance     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !out_free);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         phase_ticks_ff <= TICKS_W'(1);
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            phase_ticks_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff    <= req_tuser;
         wr_data_ff <= req_tdata[7:0];
         sda_in_ff  <= req_tdata[8];
      end
   end

   i2cbm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .kind        (kind_ff),
      .wr_data     (wr_data_ff),
      .sda_in      (sda_in_ff),
      .phase_ticks (phase_ticks_ff),
      .result      (result)
   );

   i2cbm_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/tb_i2c_bit_level_master_core.sv
// Self-checking testbench for the I2C bit-level master core: predicts every rsp transaction.
module tb_i2c_bit_level_master_core;
   import i2cbm_pkg::*;

   localparam logic [2:0] KIND_TICK_ALT6 = 3'd6;
   localparam logic [2:0] KIND_TICK_ALT7 = 3'd7;
   localparam int SDA_RANDOM   = 0;
   localparam int SDA_START_OK = 1;
   localparam int SDA_HIGH     = 2;
   localparam int SDA_LOW      = 3;
   localparam int STALL_LIMIT  = 2000;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] wr_data;
      logic       sda_in;
   } bus_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TICKS_W-1:0]    csr_data = '0;

   bus_item_type req_items[$];
   result_type   expected_lines[$];
   bus_item_type shown;
   int           stim_count = 0;
   int           fail_count = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           quiet_cycles = 0;
   bit           steady_flow = 1'b0;

   // bus model state
   logic [TICKS_W-1:0] phase_ticks_cfg = 10'd1;
   op_type             bus_op = OP_IDLE;
   logic [1:0]         bus_phase = PHASE_0;
   logic [3:0]         bus_bits = '0;
   logic [7:0]         bus_shift = '0;
   int                 bus_ticks = 0;
   logic               bus_scl = 1'b1;
   logic               bus_sda = 1'b1;
   logic               bus_ack = 1'b0;
   logic               bus_err = 1'b0;

   i2c_bit_level_master_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int eff_phase_ticks();
      return (phase_ticks_cfg == '0) ? 1 : int'(phase_ticks_cfg);
   endfunction

   function automatic logic end_of_phase(input logic sda);
      if (bus_op == OP_START) begin
         if (bus_phase == PHASE_0) begin
            if (!sda) begin
               bus_err = 1'b1;
               return 1'b1;
            end
            bus_sda = 1'b0;
            bus_phase = PHASE_1;
            return 1'b0;
         end
         if (bus_phase == PHASE_1) begin
            if (sda) begin
               bus_err = 1'b1;
               return 1'b1;
            end
            bus_scl = 1'b0;
            bus_phase = PHASE_2;
            return 1'b0;
         end
         return 1'b1;
      end
      if (bus_op == OP_STOP) begin
         if (bus_phase == PHASE_0) begin
            bus_scl = 1'b1;
            bus_phase = PHASE_1;
            return 1'b0;
         end
         if (bus_phase == PHASE_1) begin
            bus_sda = 1'b1;
            bus_phase = PHASE_2;
            return 1'b0;
         end
         return 1'b1;
      end
      if (bus_op == OP_WRITE) begin
         if (bus_bits < BITS_PER_BYTE) begin
            if (bus_phase == PHASE_0) begin
               bus_scl = 1'b1;
               bus_phase = PHASE_1;
               return 1'b0;
            end
            if (bus_phase == PHASE_1) begin
               bus_scl = 1'b0;
               bus_phase = PHASE_2;
               return 1'b0;
            end
            bus_shift = {bus_shift[6:0], 1'b0};
            bus_bits = bus_bits + 4'd1;
            if (bus_bits < BITS_PER_BYTE) bus_sda = bus_shift[7];
            bus_phase = PHASE_0;
            return 1'b0;
         end
         if (bus_phase == PHASE_0) begin
            bus_sda = 1'b1;
            bus_phase = PHASE_1;
            return 1'b0;
         end
         if (bus_phase == PHASE_1) begin
            bus_scl = 1'b1;
            bus_phase = PHASE_2;
            return 1'b0;
         end
         bus_ack = !sda;
         bus_scl = 1'b0;
         return 1'b1;
      end
      if (bus_bits < BITS_PER_BYTE) begin
         if (bus_phase == PHASE_0) begin
            bus_scl = 1'b1;
            bus_phase = PHASE_1;
            return 1'b0;
         end
         if (bus_phase == PHASE_1) begin
            bus_shift = {bus_shift[6:0], sda};
            bus_phase = PHASE_2;
            return 1'b0;
         end
         bus_scl = 1'b0;
         bus_bits = bus_bits + 4'd1;
         if (bus_bits == BITS_PER_BYTE) bus_sda = (bus_op == OP_RDNACK);
         bus_phase = PHASE_0;
         return 1'b0;
      end
      if (bus_phase == PHASE_0) begin
         bus_scl = 1'b1;
         bus_phase = PHASE_1;
         return 1'b0;
      end
      if (bus_phase == PHASE_1) begin
         bus_scl = 1'b0;
         bus_phase = PHASE_2;
         return 1'b0;
      end
      if (bus_phase == PHASE_2 && bus_op == OP_RDACK) begin
         bus_sda = 1'b1;
         bus_phase = PHASE_3;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic result_type advance_bus_model(input bus_item_type it);
      result_type r;
      logic       fin;
      fin = 1'b0;
      if (it.kind >= KIND_START && it.kind <= KIND_RDNACK) begin
         if (bus_op == OP_IDLE) begin
            bus_phase = PHASE_0;
            bus_bits = '0;
            bus_ticks = 0;
            case (it.kind)
               KIND_START: begin
                  bus_op = OP_START;
                  bus_err = 1'b0;
                  bus_scl = 1'b1;
                  bus_sda = 1'b1;
               end
               KIND_STOP: begin
                  bus_op = OP_STOP;
                  bus_sda = 1'b0;
               end
               KIND_WRITE: begin
                  bus_op = OP_WRITE;
                  bus_ack = 1'b0;
                  bus_shift = it.wr_data;
                  bus_sda = it.wr_data[7];
               end
               default: begin
                  if (it.kind == KIND_RDACK) bus_op = OP_RDACK;
                  else bus_op = OP_RDNACK;
                  bus_shift = '0;
                  bus_sda = 1'b1;
               end
            endcase
         end
      end else if (bus_op != OP_IDLE) begin
         bus_ticks++;
         if (bus_ticks >= eff_phase_ticks()) begin
            bus_ticks = 0;
            if (end_of_phase(it.sda_in)) begin
               bus_op = OP_IDLE;
               bus_phase = PHASE_0;
               bus_bits = '0;
               fin = 1'b1;
            end
         end
      end
      r.scl_level = bus_scl;
      r.sda_level = bus_sda;
      r.busy_res  = (bus_op != OP_IDLE);
      r.done_res  = fin;
      r.ack_seen  = bus_ack;
      r.rd_data   = bus_shift;
      r.status    = bus_err;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [2:0] tick_kind();
      int r;
      r = $urandom_range(19);
      if (r == 0) return KIND_TICK_ALT6;
      if (r == 1) return KIND_TICK_ALT7;
      return KIND_TICK;
   endfunction

   function automatic int phases_of(input logic [2:0] k);
      case (k)
         KIND_WRITE:  return 27;
         KIND_RDACK:  return 28;
         KIND_RDNACK: return 27;
         default:     return 3;
      endcase
   endfunction

   task automatic push_item(input logic [2:0] k, input logic [7:0] wr, input logic s);
      bus_item_type it;
      it.kind = k;
      it.wr_data = wr;
      it.sda_in = s;
      req_items.push_back(it);
      stim_count++;
   endtask

   task automatic push_op(input logic [2:0] k, input logic [7:0] wr, input int n,
                          input int sda_mode, input bit noisy);
      int   pt;
      logic s;
      pt = eff_phase_ticks();
      push_item(k, wr, 1'($urandom_range(1)));
      for (int i = 1; i <= n; i++) begin
         case (sda_mode)
            SDA_START_OK: begin
               if (i <= pt) s = 1'b1;
               else if (i <= 2 * pt) s = 1'b0;
               else s = 1'($urandom_range(1));
            end
            SDA_HIGH: s = 1'b1;
            SDA_LOW:  s = 1'b0;
            default:  s = 1'($urandom_range(1));
         endcase
         if (noisy && $urandom_range(19) == 0)
            push_item(3'($urandom_range(KIND_RDNACK, KIND_START)), 8'($urandom),
                      1'($urandom_range(1)));
         push_item(tick_kind(), 8'($urandom), s);
      end
   endtask

   task automatic random_block(input int count);
      int         goal;
      int         r;
      int         n_t;
      int         mode;
      logic [2:0] k;
      goal = stim_count + count;
      while (stim_count < goal) begin
         r = $urandom_range(99);
         if (r < 12) begin
            push_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)));
         end else begin
            r = $urandom_range(99);
            if (r < 25) k = KIND_START;
            else if (r < 40) k = KIND_STOP;
            else if (r < 70) k = KIND_WRITE;
            else if (r < 85) k = KIND_RDACK;
            else k = KIND_RDNACK;
            n_t = phases_of(k) * eff_phase_ticks();
            r = $urandom_range(9);
            if (r == 0) n_t = $urandom_range(n_t);
            else if (r < 3) n_t += $urandom_range(8);
            mode = (k == KIND_START && $urandom_range(9) != 0) ? SDA_START_OK : SDA_RANDOM;
            push_op(k, 8'($urandom), n_t, mode, 1'b1);
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (req_items.size() != 0 || req_tvalid || expected_lines.size() != 0);
   endtask

   task automatic write_phase_ticks(input logic [TICKS_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      phase_ticks_cfg = v;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_lines.push_back(advance_bus_model(shown));
            gap_left = steady_flow ? 0 : pick_gap();
            if ($urandom_range(149) == 0) steady_flow = !steady_flow;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_items.size() > 0) begin
               shown = req_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({shown.sda_in, shown.wr_data});
               req_tuser <= shown.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      result_type got;
      result_type want;
      logic       nready;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_W-1:0]);
            if (expected_lines.size() == 0) begin
               $error("unexpected rsp transaction: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_lines.pop_front();
               if (got.scl_level !== want.scl_level) begin
                  $error("scl_level expected %0d got %0d", want.scl_level, got.scl_level);
                  fail_count++;
               end
               if (got.sda_level !== want.sda_level) begin
                  $error("sda_level expected %0d got %0d", want.sda_level, got.sda_level);
                  fail_count++;
               end
               if (got.busy_res !== want.busy_res) begin
                  $error("busy_res expected %0d got %0d", want.busy_res, got.busy_res);
                  fail_count++;
               end
               if (got.done_res !== want.done_res) begin
                  $error("done_res expected %0d got %0d", want.done_res, got.done_res);
                  fail_count++;
               end
               if (got.ack_seen !== want.ack_seen) begin
                  $error("ack_seen expected %0d got %0d", want.ack_seen, got.ack_seen);
                  fail_count++;
               end
               if (got.rd_data !== want.rd_data) begin
                  $error("rd_data expected %0h got %0h", want.rd_data, got.rd_data);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            nready = 1'b0;
         end else begin
            nready = 1'b1;
            if (!steady_flow && $urandom_range(9) == 0) stall_left = pick_gap();
         end
         rsp_tready <= nready;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_i2c_bit_level_master_core: done, errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_item(KIND_TICK, 8'hFF, 1'b1);
      push_item(KIND_TICK_ALT6, 8'h00, 1'b0);
      push_item(KIND_TICK_ALT7, 8'h5A, 1'b1);
      push_op(KIND_START, 8'h00, 3, SDA_START_OK, 1'b0);
      push_op(KIND_WRITE, 8'hFF, 27, SDA_LOW, 1'b0);
      push_op(KIND_WRITE, 8'h00, 27, SDA_HIGH, 1'b0);
      // a new write starts here; the stop and read commands after it arrive mid-write and are dropped
      push_item(KIND_WRITE, 8'hA5, 1'b0);
      push_item(KIND_STOP, 8'h00, 1'b1);
      push_item(KIND_RDACK, 8'h00, 1'b0);
      push_op(KIND_TICK, 8'h00, 26, SDA_RANDOM, 1'b0);
      push_op(KIND_RDACK, 8'h00, 28, SDA_HIGH, 1'b0);
      push_op(KIND_RDNACK, 8'hFF, 27, SDA_LOW, 1'b0);
      push_op(KIND_RDNACK, 8'h00, 27, SDA_RANDOM, 1'b0);
      push_op(KIND_STOP, 8'h00, 3, SDA_RANDOM, 1'b0);
      push_op(KIND_START, 8'h00, 1, SDA_LOW, 1'b0);
      push_op(KIND_START, 8'h00, 2, SDA_HIGH, 1'b0);
      push_op(KIND_START, 8'hFF, 3, SDA_START_OK, 1'b0);
      wait_drained();

      write_phase_ticks(10'd0);
      random_block(130);
      wait_drained();

      write_phase_ticks(10'd300);
      push_op(KIND_START, 8'h00, 300, SDA_LOW, 1'b0);
      push_item(KIND_TICK, 8'h00, 1'b1);
      wait_drained();

      // hold a start in its first phase, then shorten the phase under it
      write_phase_ticks(10'd1023);
      push_op(KIND_START, 8'h00, 40, SDA_HIGH, 1'b0);
      wait_drained();

      write_phase_ticks(10'd2);
      random_block(150);
      wait_drained();

      write_phase_ticks(10'd3);
      random_block(150);
      wait_drained();

      write_phase_ticks(10'd1);
      random_block(130);
      wait_drained();

      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_i2c_bit_level_master_core: done, clean");
      end else begin
         $display("tb_i2c_bit_level_master_core: done, errors");
      end
      $finish;
   end

endmodule
